// ----- src/wlf_pkg.sv -----
// shared constants and types of the word length filter
package wlf_pkg;

    localparam int MAX_WORD  = 32;
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = $clog2(MAX_WORD);
    localparam int CNT_W     = $clog2(MAX_WORD + 2);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 6'd0;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 6'd32;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [CHAR_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } t_ram_req;

endpackage

// ----- src/wlf_if.sv -----
// channel interfaces of the word length filter
interface wlf_in_if;
    logic                       valid;
    logic                       ready;
    logic [wlf_pkg::CHAR_W-1:0] ch;
    logic                       end_of_string;

    modport source (output valid, output ch, output end_of_string, input ready);
    modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

interface wlf_out_if;
    logic                       valid;
    logic                       ready;
    logic [wlf_pkg::CHAR_W-1:0] out_ch;
    logic                       has_char;
    logic                       last;

    modport source (output valid, output out_ch, output has_char, output last, input ready);
    modport sink   (input valid, input out_ch, input has_char, input last, output ready);
endinterface

interface wlf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wlf_pkg::CFG_IDX_W-1:0] index;
    logic [wlf_pkg::LEN_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/wlf_word_ram.sv -----
// word buffer memory with one write port and one registered read port
module wlf_word_ram (
    input  logic                       i_clk,
    input  wlf_pkg::t_ram_req          i_req,
    output logic [wlf_pkg::CHAR_W-1:0] o_rd_data
);

    logic [wlf_pkg::CHAR_W-1:0] r_mem [wlf_pkg::MAX_WORD];
    logic [wlf_pkg::CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/word_length_filter.sv -----
// top level of the word length filter
// Takes one character per transfer; space and tab end a word. A delimiter that closes a
// kept word starts its output: a separating space before every kept word but the first,
// then each character is read from the word buffer's registered read port and then loaded
// into the output register; end of string adds the end marker.
// The input is not ready while a word is being sent, and every output step also waits on the
// output register when the sink stalls. Configuration is always ready.
module word_length_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wlf_in_if.sink            i_in,
    wlf_out_if.source         o_out,
    wlf_cfg_if.sink           i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SPACE = 5'b00010,
        S_READ  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_END   = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [wlf_pkg::CNT_W-1:0]      r_count, n_count;
    logic [wlf_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                           r_any_emitted, n_any_emitted;
    logic                           r_eos_pend, n_eos_pend;
    logic [wlf_pkg::LEN_W-1:0]      r_min_length, r_max_length;

    logic                           r_out_valid, n_out_valid;
    logic [wlf_pkg::CHAR_W-1:0]     r_out_ch, n_out_ch;
    logic                           r_out_has, n_out_has;
    logic                           r_out_last, n_out_last;

    wlf_pkg::t_ram_req              ram_req;
    logic [wlf_pkg::CHAR_W-1:0]     rd_data;

    logic in_xfer, out_free, is_delim, kept, last_char;

    wlf_word_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign is_delim    = (i_in.ch == wlf_pkg::CHAR_SPACE) || (i_in.ch == wlf_pkg::CHAR_TAB);

    // length judge on the current word
    assign kept = (r_count != '0)
               && (r_count <= wlf_pkg::CNT_W'(wlf_pkg::MAX_WORD))
               && (r_count >= wlf_pkg::CNT_W'(r_min_length))
               && (r_count <= wlf_pkg::CNT_W'(r_max_length));

    assign last_char = (wlf_pkg::CNT_W'(r_idx) + wlf_pkg::CNT_W'(1)) == r_count;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_ch   = r_out_ch;
    assign o_out.has_char = r_out_has;
    assign o_out.last     = r_out_last;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_any_emitted = r_any_emitted;
        n_eos_pend    = r_eos_pend;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_ch      = r_out_ch;
        n_out_has     = r_out_has;
        n_out_last    = r_out_last;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = r_count[wlf_pkg::IDX_W-1:0];
        ram_req.wr_data = i_in.ch;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.end_of_string || is_delim) begin
                        n_eos_pend = i_in.end_of_string;
                        n_idx      = '0;
                        if (kept) begin
                            n_state = r_any_emitted ? S_SPACE : S_READ;
                        end else begin
                            n_count = '0;
                            n_state = i_in.end_of_string ? S_END : S_IDLE;
                        end
                    end else begin
                        if (r_count < wlf_pkg::CNT_W'(wlf_pkg::MAX_WORD)) begin
                            ram_req.wr_en = 1'b1;
                        end
                        if (r_count <= wlf_pkg::CNT_W'(wlf_pkg::MAX_WORD)) begin
                            n_count = r_count + wlf_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            S_SPACE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = wlf_pkg::CHAR_SPACE;
                    n_out_has   = 1'b1;
                    n_out_last  = 1'b0;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                ram_req.rd_en = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ch    = rd_data;
                    n_out_has   = 1'b1;
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + wlf_pkg::IDX_W'(1);
                    if (last_char) begin
                        n_any_emitted = 1'b1;
                        n_count       = '0;
                        n_state       = r_eos_pend ? S_END : S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_ch      = wlf_pkg::CHAR_NONE;
                    n_out_has     = 1'b0;
                    n_out_last    = 1'b1;
                    n_count       = '0;
                    n_any_emitted = 1'b0;
                    n_eos_pend    = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_idx         <= '0;
            r_any_emitted <= 1'b0;
            r_eos_pend    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_min_length  <= wlf_pkg::MIN_LENGTH_RESET;
            r_max_length  <= wlf_pkg::MAX_LENGTH_RESET;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_idx         <= n_idx;
            r_any_emitted <= n_any_emitted;
            r_eos_pend    <= n_eos_pend;
            r_out_valid   <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    wlf_pkg::REG_MIN_LENGTH: r_min_length <= i_cfg.data;
                    wlf_pkg::REG_MAX_LENGTH: r_max_length <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out_ch   <= n_out_ch;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wlf_pkg::CNT_W'(wlf_pkg::MAX_WORD + 1))
        else $error("word count beyond saturation");

    a_emit_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (wlf_pkg::CNT_W'(r_idx) < r_count))
        else $error("buffer read past end of word");

    a_eos_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.end_of_string) |=> (r_state != S_IDLE))
        else $error("end of string without end marker");

    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && out_free) |=> (r_out_valid && r_out_last && !r_any_emitted))
        else $error("end marker not loaded");
`endif

endmodule
